### rtl/core/display_idle_dim_off_controller_macros.svh
// Assertion macros for the display idle controller checks.
// Included by the checker; needs clk and rst_n in the including scope.
`ifndef DISPLAY_IDLE_DIM_OFF_CONTROLLER_MACROS_SVH
`define DISPLAY_IDLE_DIM_OFF_CONTROLLER_MACROS_SVH

// Property checked outside of reset
`define DIDO_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dido check failed");

// Property checked on every edge, reset included
`define DIDO_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("dido reset check failed");

`endif

### rtl/core/dido_pkg.sv
// Shared types and constants for the display idle dim/off controller.
// No dependencies; used by every module of the block.
package dido_pkg;

    // Command codes (input tuser)
    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_ACTIVITY = 2'd1;
    localparam logic [1:0] CMD_WAKE     = 2'd2;

    // Power modes
    localparam logic [1:0] MODE_ACTIVE = 2'd0;
    localparam logic [1:0] MODE_DIM    = 2'd1;
    localparam logic [1:0] MODE_OFF    = 2'd2;

    // Display actions
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_OFF  = 2'd1;
    localparam logic [1:0] ACT_ON   = 2'd2;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_ACTIVE_LEVEL = 2'd0;
    localparam logic [1:0] REG_DIM_LEVEL    = 2'd1;
    localparam logic [1:0] REG_DIM_TIMEOUT  = 2'd2;
    localparam logic [1:0] REG_OFF_TIMEOUT  = 2'd3;

    // Timeout thresholds in ms: 65535 * 1000 fits in 26 bits
    localparam int unsigned THR_W      = 26;
    localparam int unsigned MS_PER_SEC = 1000;

    localparam logic [3:0]  ACTIVE_LEVEL_RST = 4'd15;
    localparam logic [3:0]  DIM_LEVEL_RST    = 4'd3;
    localparam logic [15:0] DIM_SEC_RST      = 16'd30;
    localparam logic [15:0] OFF_SEC_RST      = 16'd60;

    // Settings seen by the step logic
    typedef struct packed {
        logic [3:0]       active_level;
        logic [3:0]       dim_level;
        logic [THR_W-1:0] dim_thr_ms;
        logic [THR_W-1:0] off_thr_ms;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic       sleep_request;
        logic [1:0] display_action;
        logic [3:0] level_value;
        logic       level_apply;
        logic [1:0] power_mode;
    } res_t;

endpackage

### rtl/core/dido_cfg.sv
// APB register file for the display idle controller; scales timeouts to ms.
// Depends on dido_pkg.
module dido_cfg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output dido_pkg::cfg_t     cfg
);

    logic [3:0]                 active_level_reg;
    logic [3:0]                 dim_level_reg;
    logic [15:0]                dim_sec_reg;
    logic [15:0]                off_sec_reg;
    logic [dido_pkg::THR_W-1:0] dim_thr_reg;
    logic [dido_pkg::THR_W-1:0] off_thr_reg;
    logic [dido_pkg::THR_W-1:0] wr_thr;
    logic                       wr_en;
    logic [1:0]                 idx;

    assign wr_en = psel && penable && pwrite;
    assign idx   = paddr[3:2];

    // seconds to milliseconds, done once at write time
    assign wr_thr = dido_pkg::THR_W'(pwdata[15:0])
                  * dido_pkg::THR_W'(dido_pkg::MS_PER_SEC);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_level_reg <= dido_pkg::ACTIVE_LEVEL_RST;
            dim_level_reg    <= dido_pkg::DIM_LEVEL_RST;
            dim_sec_reg      <= dido_pkg::DIM_SEC_RST;
            off_sec_reg      <= dido_pkg::OFF_SEC_RST;
            dim_thr_reg      <= dido_pkg::THR_W'(dido_pkg::DIM_SEC_RST)
                              * dido_pkg::THR_W'(dido_pkg::MS_PER_SEC);
            off_thr_reg      <= dido_pkg::THR_W'(dido_pkg::OFF_SEC_RST)
                              * dido_pkg::THR_W'(dido_pkg::MS_PER_SEC);
        end
        else if (wr_en)
        begin
            case (idx)
                dido_pkg::REG_ACTIVE_LEVEL: active_level_reg <= pwdata[3:0];
                dido_pkg::REG_DIM_LEVEL:    dim_level_reg    <= pwdata[3:0];
                dido_pkg::REG_DIM_TIMEOUT:
                begin
                    dim_sec_reg <= pwdata[15:0];
                    dim_thr_reg <= wr_thr;
                end
                dido_pkg::REG_OFF_TIMEOUT:
                begin
                    off_sec_reg <= pwdata[15:0];
                    off_thr_reg <= wr_thr;
                end
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            dido_pkg::REG_ACTIVE_LEVEL: prdata = {28'd0, active_level_reg};
            dido_pkg::REG_DIM_LEVEL:    prdata = {28'd0, dim_level_reg};
            dido_pkg::REG_DIM_TIMEOUT:  prdata = {16'd0, dim_sec_reg};
            dido_pkg::REG_OFF_TIMEOUT:  prdata = {16'd0, off_sec_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    assign cfg.active_level = active_level_reg;
    assign cfg.dim_level    = dim_level_reg;
    assign cfg.dim_thr_ms   = dim_thr_reg;
    assign cfg.off_thr_ms   = off_thr_reg;

endmodule

### rtl/core/dido_fsm.sv
// Power mode state and per-item step logic of the display idle controller.
// Depends on dido_pkg.
module dido_fsm
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic [1:0]     cmd,
    input  logic [31:0]    now_ms,
    input  dido_pkg::cfg_t cfg,
    output dido_pkg::res_t res
);

    logic [1:0]  mode_reg;
    logic [1:0]  mode_next;
    logic [31:0] last_act_reg;
    logic [31:0] last_act_next;
    logic [31:0] dim_entry_reg;
    logic [31:0] dim_entry_next;
    logic        sleep_reg;
    logic        sleep_next;
    logic        scr_off_reg;
    logic        scr_off_next;
    logic [31:0] idle_ms;
    logic [31:0] dim_ms;
    logic        dim_due;
    logic        off_due;
    logic        apply;
    logic [3:0]  level;
    logic [1:0]  action;

    // elapsed times, modulo 2^32
    assign idle_ms = now_ms - last_act_reg;
    assign dim_ms  = now_ms - dim_entry_reg;
    assign dim_due = (cfg.dim_thr_ms != '0) && (idle_ms >= 32'(cfg.dim_thr_ms));
    assign off_due = (cfg.off_thr_ms != '0) && (dim_ms >= 32'(cfg.off_thr_ms));

    // next state and actions for one item
    always_comb
    begin
        mode_next      = mode_reg;
        last_act_next  = last_act_reg;
        dim_entry_next = dim_entry_reg;
        sleep_next     = sleep_reg;
        scr_off_next   = scr_off_reg;
        apply          = 1'b0;
        level          = 4'd0;
        action         = dido_pkg::ACT_NONE;
        case (cmd)
            dido_pkg::CMD_TICK:
            begin
                if (!sleep_reg)
                begin
                    if (mode_reg == dido_pkg::MODE_ACTIVE)
                    begin
                        if (dim_due)
                        begin
                            mode_next      = dido_pkg::MODE_DIM;
                            dim_entry_next = now_ms;
                            apply          = 1'b1;
                            level          = cfg.dim_level;
                        end
                    end
                    else if (mode_reg == dido_pkg::MODE_DIM)
                    begin
                        if (off_due)
                        begin
                            mode_next  = dido_pkg::MODE_OFF;
                            sleep_next = 1'b1;
                            if (!scr_off_reg)
                            begin
                                scr_off_next = 1'b1;
                                action       = dido_pkg::ACT_OFF;
                            end
                        end
                    end
                end
            end
            dido_pkg::CMD_ACTIVITY:
            begin
                last_act_next = now_ms;
                if (mode_reg != dido_pkg::MODE_ACTIVE)
                begin
                    mode_next = dido_pkg::MODE_ACTIVE;
                    apply     = 1'b1;
                    level     = cfg.active_level;
                    if (scr_off_reg)
                    begin
                        scr_off_next = 1'b0;
                        action       = dido_pkg::ACT_ON;
                    end
                end
            end
            dido_pkg::CMD_WAKE:
            begin
                scr_off_next  = 1'b0;
                mode_next     = dido_pkg::MODE_ACTIVE;
                last_act_next = now_ms;
                sleep_next    = 1'b0;
                action        = dido_pkg::ACT_ON;
                apply         = 1'b1;
                level         = cfg.active_level;
            end
            default: ;
        endcase
    end

    // state update when the item leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= dido_pkg::MODE_ACTIVE;
            last_act_reg  <= 32'd0;
            dim_entry_reg <= 32'd0;
            sleep_reg     <= 1'b0;
            scr_off_reg   <= 1'b0;
        end
        else if (step)
        begin
            mode_reg      <= mode_next;
            last_act_reg  <= last_act_next;
            dim_entry_reg <= dim_entry_next;
            sleep_reg     <= sleep_next;
            scr_off_reg   <= scr_off_next;
        end
    end

    assign res.power_mode     = mode_next;
    assign res.level_apply    = apply;
    assign res.level_value    = level;
    assign res.display_action = action;
    assign res.sleep_request  = sleep_next;

endmodule

### rtl/core/display_idle_dim_off_controller.sv
// Top level of the display idle dim/off controller.
// Depends on dido_pkg, dido_cfg and dido_fsm.
//
// Usage:
//   Input stream (s_axis_*): one item per event; tuser carries the command
//   (tick, user activity, wake) and tdata the 32-bit millisecond time.
//   Output stream (m_axis_*): one result item per input item, in order,
//   carrying mode, level write request, level, display action and sleep
//   request.
//   APB port: four settings registers at byte offsets 0, 4, 8, 12
//   (active level, dim level, dim timeout s, off timeout s); pready is
//   always high, writes complete in the access cycle.
// Timing:
//   An item accepted into the input register is evaluated against the power
//   state and registered as a result once the result register is empty or
//   m_axis_tready is high; m_axis_tvalid rises with that result. One item per
//   cycle is sustained while m_axis_tready stays high; the input register and
//   the result register form a two-deep pipeline.
// Reset: rst_n (async, active low) clears both stages, returns to active
//   mode and loads the settings defaults.
// Stall: while m_axis_tready is low the result holds; one more item may be
//   taken into the input register, then s_axis_tready drops.
module display_idle_dim_off_controller
(
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] now_ms
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [1:0] power_mode, [2] level_apply,
                                        // [6:3] level_value, [8:7] display_action,
                                        // [9] sleep_request, [15:10] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dido_pkg::cfg_t cfg;
    dido_pkg::res_t res;
    dido_pkg::res_t out_data_reg;
    logic           in_valid_reg;
    logic [1:0]     in_cmd_reg;
    logic [31:0]    in_now_reg;
    logic           out_valid_reg;
    logic           step;

    assign pready = 1'b1;

    dido_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // item moves from input register to result register
    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    dido_fsm u_fsm
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .cmd    (in_cmd_reg),
        .now_ms (in_now_reg),
        .cfg    (cfg),
        .res    (res)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_cmd_reg <= s_axis_tuser;
            in_now_reg <= s_axis_tdata;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_data_reg};

endmodule

### rtl/core/dido_checker.sv
// Port-level checks for the display idle controller, bound to the top level.
// Depends on dido_pkg and display_idle_dim_off_controller_macros.svh.
`include "display_idle_dim_off_controller_macros.svh"

module dido_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // a stalled result holds
    `DIDO_ASSERT(a_out_hold,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

    // level is zero unless a write is requested
    `DIDO_ASSERT(a_level_zero,
        m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[6:3] == 4'd0)

    // display-off only on entry to off mode with sleep raised
    `DIDO_ASSERT(a_off_entry,
        m_axis_tvalid && m_axis_tdata[8:7] == dido_pkg::ACT_OFF |->
            m_axis_tdata[1:0] == dido_pkg::MODE_OFF && m_axis_tdata[9])

    // display-on comes with active mode and a level write
    `DIDO_ASSERT(a_on_active,
        m_axis_tvalid && m_axis_tdata[8:7] == dido_pkg::ACT_ON |->
            m_axis_tdata[1:0] == dido_pkg::MODE_ACTIVE && m_axis_tdata[2])

    // no result right out of reset
    `DIDO_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !m_axis_tvalid)

endmodule

bind display_idle_dim_off_controller dido_checker u_dido_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### tb/display_idle_dim_off_controller_tb.sv
// Testbench for display_idle_dim_off_controller: directed and random event streams
// checked item by item against a behavioral predictor of the power state.
// Depends on dido_pkg and the RTL of the block; needs no other file.
module display_idle_dim_off_controller_tb;

    // Command code that the block does not use
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;     // [31:0] now_ms
    logic [1:0]  s_axis_tuser;     // [1:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;     // [1:0] power_mode, [2] level_apply, [6:3] level_value,
                                   // [8:7] display_action, [9] sleep_request, [15:10] zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the settings registers
    logic [3:0]  active_lvl;
    logic [3:0]  dim_lvl;
    logic [15:0] dim_timeout_s;
    logic [15:0] off_timeout_s;

    // Predicted power state
    logic [1:0]  pwr_mode;
    logic [31:0] last_activity_ms;
    logic [31:0] dim_start_ms;
    logic        sleep_pending;
    logic        screen_off;

    dido_pkg::res_t pending_results[$];
    int          mismatch_count = 0;
    bit          tx_gaps_on;
    bit          rx_gaps_on;
    int          rx_stall_left;
    logic [31:0] time_cursor;

    display_idle_dim_off_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #1000000;
        $display("Verification failed");
        $finish;
    end

    // Next power state and result for one event; updates the predicted state
    function automatic dido_pkg::res_t predict_event(input logic [1:0] cmd,
                                                     input logic [31:0] now);
        dido_pkg::res_t r;
        logic [31:0]    idle_ms;
        logic [31:0]    in_dim_ms;
        r = '0;
        case (cmd)
            dido_pkg::CMD_TICK:
            begin
                if (!sleep_pending)
                begin
                    idle_ms   = now - last_activity_ms;
                    in_dim_ms = now - dim_start_ms;
                    if (pwr_mode == dido_pkg::MODE_ACTIVE)
                    begin
                        if (dim_timeout_s != 0 &&
                            idle_ms >= 32'(dim_timeout_s) * dido_pkg::MS_PER_SEC)
                        begin
                            pwr_mode      = dido_pkg::MODE_DIM;
                            dim_start_ms  = now;
                            r.level_apply = 1'b1;
                            r.level_value = dim_lvl;
                        end
                    end
                    else if (pwr_mode == dido_pkg::MODE_DIM)
                    begin
                        if (off_timeout_s != 0 &&
                            in_dim_ms >= 32'(off_timeout_s) * dido_pkg::MS_PER_SEC)
                        begin
                            pwr_mode = dido_pkg::MODE_OFF;
                            if (!screen_off)
                            begin
                                screen_off       = 1'b1;
                                r.display_action = dido_pkg::ACT_OFF;
                            end
                            sleep_pending = 1'b1;
                        end
                    end
                end
            end
            dido_pkg::CMD_ACTIVITY:
            begin
                last_activity_ms = now;
                if (pwr_mode != dido_pkg::MODE_ACTIVE)
                begin
                    pwr_mode = dido_pkg::MODE_ACTIVE;
                    if (screen_off)
                    begin
                        screen_off       = 1'b0;
                        r.display_action = dido_pkg::ACT_ON;
                    end
                    r.level_apply = 1'b1;
                    r.level_value = active_lvl;
                end
            end
            dido_pkg::CMD_WAKE:
            begin
                screen_off       = 1'b0;
                pwr_mode         = dido_pkg::MODE_ACTIVE;
                last_activity_ms = now;
                sleep_pending    = 1'b0;
                r.display_action = dido_pkg::ACT_ON;
                r.level_apply    = 1'b1;
                r.level_value    = active_lvl;
            end
            default:
            begin
                // unused code: no state change, no actions
            end
        endcase
        r.power_mode    = pwr_mode;
        r.sleep_request = sleep_pending;
        return r;
    endfunction

    // Result checker
    always @(posedge clk)
    begin : result_check
        dido_pkg::res_t got;
        dido_pkg::res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = dido_pkg::res_t'(m_axis_tdata[9:0]);
            if (pending_results.size() == 0)
            begin
                $error("unexpected result item: tdata %h", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.power_mode !== want.power_mode)
                begin
                    $error("power_mode: expected %0d, got %0d", want.power_mode, got.power_mode);
                    mismatch_count++;
                end
                if (got.level_apply !== want.level_apply)
                begin
                    $error("level_apply: expected %0d, got %0d",
                           want.level_apply, got.level_apply);
                    mismatch_count++;
                end
                if (got.level_value !== want.level_value)
                begin
                    $error("level_value: expected %0d, got %0d",
                           want.level_value, got.level_value);
                    mismatch_count++;
                end
                if (got.display_action !== want.display_action)
                begin
                    $error("display_action: expected %0d, got %0d",
                           want.display_action, got.display_action);
                    mismatch_count++;
                end
                if (got.sleep_request !== want.sleep_request)
                begin
                    $error("sleep_request: expected %0d, got %0d",
                           want.sleep_request, got.sleep_request);
                    mismatch_count++;
                end
                if (m_axis_tdata[15:10] !== 6'd0)
                begin
                    $error("tdata padding: expected 0, got %0d", m_axis_tdata[15:10]);
                    mismatch_count++;
                end
            end
        end
    end

    // Result side: ready with random stall bursts
    initial
    begin
        rx_stall_left = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_stall_left > 0)
            begin
                rx_stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_gaps_on && $urandom_range(0, 9) == 0)
            begin
                rx_stall_left = int'($urandom_range(1, 19)) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Register write over APB; junk in the unused upper bits
    task automatic write_setting(input logic [1:0] idx, input logic [15:0] value);
        logic [31:0] word;
        word = $urandom;
        case (idx)
            dido_pkg::REG_ACTIVE_LEVEL:
            begin
                word[3:0]  = value[3:0];
                active_lvl = value[3:0];
            end
            dido_pkg::REG_DIM_LEVEL:
            begin
                word[3:0] = value[3:0];
                dim_lvl   = value[3:0];
            end
            dido_pkg::REG_DIM_TIMEOUT:
            begin
                word[15:0]    = value;
                dim_timeout_s = value;
            end
            default:
            begin
                word[15:0]    = value;
                off_timeout_s = value;
            end
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_all(input logic [3:0] act, input logic [3:0] dim,
                           input logic [15:0] dim_s, input logic [15:0] off_s);
        write_setting(dido_pkg::REG_ACTIVE_LEVEL, 16'(act));
        write_setting(dido_pkg::REG_DIM_LEVEL, 16'(dim));
        write_setting(dido_pkg::REG_DIM_TIMEOUT, dim_s);
        write_setting(dido_pkg::REG_OFF_TIMEOUT, off_s);
    endtask

    // Send one event item; called and returns at a falling edge
    task automatic send_event(input logic [1:0] cmd, input logic [31:0] now);
        if (tx_gaps_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        pending_results.push_back(predict_event(cmd, now));
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= now;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Wait for all outstanding results, then let the block settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Random event stream: mostly time advancing in small steps, some noise
    task automatic run_traffic(input int n_items, input int step_max, input int pause_at);
        int          pick;
        logic [1:0]  cmd;
        logic [31:0] now;
        for (int i = 0; i < n_items; i++)
        begin
            if (i == pause_at)
                wait_drained();
            pick = $urandom_range(0, 99);
            time_cursor += $urandom_range(0, step_max);
            now = time_cursor;
            if (pick < 65)
                cmd = dido_pkg::CMD_TICK;
            else if (pick < 82)
                cmd = dido_pkg::CMD_ACTIVITY;
            else if (pick < 90)
                cmd = dido_pkg::CMD_WAKE;
            else
            begin
                // noise: random command at a random time
                cmd = ($urandom_range(0, 2) == 0) ? dido_pkg::CMD_TICK :
                      ($urandom_range(0, 1) == 0) ? dido_pkg::CMD_ACTIVITY :
                                                    dido_pkg::CMD_WAKE;
                now = $urandom;
                if ($urandom_range(0, 1) == 0)
                    time_cursor = now;
            end
            send_event(cmd, now);
        end
        wait_drained();
    endtask

    // Full dim and off sequence with reset settings, wrap of the time base
    task automatic test_dim_off_sequence();
        send_event(dido_pkg::CMD_ACTIVITY, 32'd1000);
        send_event(dido_pkg::CMD_TICK, 32'd30999);
        send_event(dido_pkg::CMD_TICK, 32'd31000);
        send_event(dido_pkg::CMD_TICK, 32'd90999);
        send_event(dido_pkg::CMD_TICK, 32'd91000);
        send_event(dido_pkg::CMD_TICK, 32'd200000000);      // sleep pending: ignored
        send_event(dido_pkg::CMD_ACTIVITY, 32'd200000001);  // screen on, sleep stays
        send_event(dido_pkg::CMD_TICK, 32'hFFFF_FFFF);
        send_event(CMD_UNUSED, 32'h1234_5678);              // unused command code
        send_event(dido_pkg::CMD_WAKE, 32'hFFFF_F000);
        send_event(dido_pkg::CMD_ACTIVITY, 32'hFFFF_F000);  // activity while active
        send_event(dido_pkg::CMD_TICK, 32'h0000_6A00);      // idle time wraps past zero
        send_event(dido_pkg::CMD_ACTIVITY, 32'h0000_7000);  // level reapplied, screen already on
        send_event(dido_pkg::CMD_WAKE, 32'd0);
        wait_drained();
    endtask

    // Disabled and largest timeouts, level extremes
    task automatic test_timeout_extremes();
        set_all(4'd0, 4'd15, 16'd0, 16'd65535);
        send_event(dido_pkg::CMD_TICK, 32'hFFFF_FFFF);      // dimming disabled
        send_event(dido_pkg::CMD_TICK, 32'h8000_0000);
        wait_drained();
        set_all(4'd15, 4'd0, 16'd65535, 16'd0);
        send_event(dido_pkg::CMD_ACTIVITY, 32'd0);
        send_event(dido_pkg::CMD_TICK, 32'd65534999);
        send_event(dido_pkg::CMD_TICK, 32'd65535000);
        send_event(dido_pkg::CMD_TICK, 32'hFFFF_FFFF);      // off disabled
        wait_drained();
        write_setting(dido_pkg::REG_OFF_TIMEOUT, 16'd65535);
        send_event(dido_pkg::CMD_TICK, 32'd131069999);
        send_event(dido_pkg::CMD_TICK, 32'd131070000);
        send_event(dido_pkg::CMD_WAKE, 32'd0);
        wait_drained();
    endtask

    task automatic test_traffic_reset_timeouts();
        set_all(4'd15, 4'd3, 16'd30, 16'd60);
        run_traffic(300, 25000, -1);
    endtask

    task automatic test_traffic_short_timeouts();
        set_all(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 16'd1, 16'd2);
        run_traffic(300, 1500, 150);
    endtask

    task automatic test_traffic_dim_disabled();
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        set_all(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 16'd0, 16'd3);
        run_traffic(250, 3000, -1);
    endtask

    task automatic test_traffic_off_disabled();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        set_all(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 16'd2, 16'd0);
        run_traffic(250, 2500, -1);
    endtask

    task automatic test_traffic_max_timeouts();
        rx_gaps_on = 1'b0;
        set_all(4'd15, 4'd0, 16'd65535, 16'd65535);
        run_traffic(250, 30000000, -1);
    endtask

    task automatic test_traffic_no_idling();
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        set_all(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                16'($urandom_range(1, 10)), 16'($urandom_range(1, 10)));
        run_traffic(300, 4000, -1);
    endtask

    // Main sequence
    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = dido_pkg::CMD_TICK;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        tx_gaps_on     = 1'b1;
        rx_gaps_on     = 1'b1;
        time_cursor    = '0;

        active_lvl       = dido_pkg::ACTIVE_LEVEL_RST;
        dim_lvl          = dido_pkg::DIM_LEVEL_RST;
        dim_timeout_s    = dido_pkg::DIM_SEC_RST;
        off_timeout_s    = dido_pkg::OFF_SEC_RST;
        pwr_mode         = dido_pkg::MODE_ACTIVE;
        last_activity_ms = '0;
        dim_start_ms     = '0;
        sleep_pending    = 1'b0;
        screen_off       = 1'b0;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_dim_off_sequence();
        test_timeout_extremes();
        test_traffic_reset_timeouts();
        test_traffic_short_timeouts();
        test_traffic_dim_disabled();
        test_traffic_off_disabled();
        test_traffic_max_timeouts();
        test_traffic_no_idling();

        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/dido_pkg.sv
rtl/core/dido_cfg.sv
rtl/core/dido_fsm.sv
rtl/core/display_idle_dim_off_controller.sv
rtl/core/dido_checker.sv
tb/display_idle_dim_off_controller_tb.sv
